// ----- rtl/inverse_wavelet_lifting_1d_defines.svh -----
// Assertion macros used by the checker file of the inverse lifting block.
// Needs nothing else; include by bare file name.
`ifndef INVERSE_WAVELET_LIFTING_1D_DEFINES_SVH
`define INVERSE_WAVELET_LIFTING_1D_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IWL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iwl check failed");

// The consequent must hold in the cycle after the antecedent.
`define IWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iwl check failed");

`endif

// ----- rtl/iwl_pkg.sv -----
// Shared types, constants and helper functions of the inverse lifting block.
// No dependencies; imported by the interfaces, datapath, controller, top level and testbench.
`timescale 1ns / 1ps

package iwl_pkg;

    localparam int MAX_PAIRS  = 32;
    localparam int ADDR_W     = $clog2(MAX_PAIRS);
    localparam int CNT_W      = $clog2(MAX_PAIRS + 1);
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 24;
    localparam int TAP_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // Wavelet codes; code 3 behaves as Haar.
    localparam logic [1:0] WK_HAAR  = 2'd0;
    localparam logic [1:0] WK_CDF53 = 2'd1;
    localparam logic [1:0] WK_DD137 = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WAVELET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE    = 1'b1;

    typedef enum logic [1:0] {
        COEF_P1 = 2'd0,
        COEF_M1 = 2'd1,
        COEF_P9 = 2'd2,
        COEF_M9 = 2'd3
    } coef_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              cnt_clr;
        logic              rd_tap;
        logic              rd_base;
        logic              acc_en;
        logic              acc_clr;
        logic              even_we;
        logic              out_even;
        logic              out_odd;
        logic              out_err;
        logic              odd;
        logic              last_idx;
        logic [ADDR_W-1:0] idx;
        logic [TAP_W-1:0]  tap;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             row_err;
        logic [1:0]       kind;
    } dp_status_t;

    // Number of neighbor taps accumulated before the base read.
    function automatic logic [2:0] tap_count(input logic [1:0] kind);
        logic [2:0] r;
        r = 3'd0;
        if (kind == WK_CDF53)
            r = 3'd2;
        else if (kind == WK_DD137)
            r = 3'd4;
        return r;
    endfunction

    // Offset of a tap from the current index.
    function automatic logic signed [2:0] tap_offset(input logic [1:0] kind,
                                                     input logic odd,
                                                     input logic [TAP_W-1:0] k);
        logic signed [2:0] r;
        r = 3'sd0;
        if (kind == WK_CDF53) begin
            if (odd)
                r = (k == 2'd0) ? 3'sd1 : 3'sd0;
            else
                r = (k == 2'd0) ? 3'sd0 : -3'sd1;
        end else if (kind == WK_DD137) begin
            unique case (k)
                2'd0: r = odd ? 3'sd2 : 3'sd1;
                2'd1: r = odd ? -3'sd1 : -3'sd2;
                2'd2: r = odd ? 3'sd1 : 3'sd0;
                2'd3: r = odd ? 3'sd0 : -3'sd1;
                default: r = 3'sd0;
            endcase
        end
        return r;
    endfunction

    // Weight of a tap.
    function automatic coef_t tap_coef(input logic [1:0] kind, input logic odd,
                                       input logic [TAP_W-1:0] k);
        coef_t r;
        r = COEF_P1;
        if (kind == WK_DD137) begin
            if (k[1])
                r = odd ? COEF_M9 : COEF_P9;
            else
                r = odd ? COEF_P1 : COEF_M1;
        end
        return r;
    endfunction

    // Edge handling: periodic wrap or replicate the edge entry.
    function automatic logic [ADDR_W-1:0] pick(input logic [ADDR_W-1:0] i,
                                               input logic signed [2:0] off,
                                               input logic [CNT_W-1:0] n,
                                               input logic rep);
        logic signed [CNT_W+1:0] j;
        logic signed [CNT_W+1:0] nn;
        logic signed [CNT_W+1:0] r;
        j  = $signed({3'b000, i}) + $signed({{(CNT_W-1){off[2]}}, off});
        nn = $signed({2'b00, n});
        if (j < 0)
            r = rep ? '0 : j + nn;
        else if (j >= nn)
            r = rep ? nn - (CNT_W+2)'(1) : j - nn;
        else
            r = j;
        return r[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/iwl_pair_if.sv -----
// Input channel carrying one lowpass/highpass pair per item.
// Depends on iwl_pkg for the sample width.
`timescale 1ns / 1ps

interface iwl_pair_if;
    import iwl_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] low_sample;
    logic signed [DATA_W-1:0] high_sample;
    logic signed [DATA_W-1:0] scale;
    logic                     last_pair;

    modport source (output valid, low_sample, high_sample, scale, last_pair, input ready);
    modport sink (input valid, low_sample, high_sample, scale, last_pair, output ready);
endinterface

// ----- rtl/iwl_sample_if.sv -----
// Output channel carrying one reconstructed sample per item.
// Depends on iwl_pkg for the sample width.
`timescale 1ns / 1ps

interface iwl_sample_if;
    import iwl_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
    logic                     error;

    modport source (output valid, sample, last_sample, error, input ready);
    modport sink (input valid, sample, last_sample, error, output ready);
endinterface

// ----- rtl/iwl_datapath.sv -----
// Datapath: coefficient stores, tap accumulator, lifting arithmetic, output register.
// Depends on iwl_pkg; driven by iwl_controller commands.
`timescale 1ns / 1ps

module iwl_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  iwl_pkg::ctrl_cmd_t               cmd,
    input  logic signed [iwl_pkg::DATA_W-1:0] low_sample,
    input  logic signed [iwl_pkg::DATA_W-1:0] high_sample,
    input  logic signed [iwl_pkg::DATA_W-1:0] scale,
    input  logic                             cfg_we,
    input  logic [iwl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iwl_pkg::CFG_DATA_W-1:0]   cfg_data,
    output iwl_pkg::dp_status_t              status,
    output logic signed [iwl_pkg::DATA_W-1:0] out_sample,
    output logic                             out_last,
    output logic                             out_error
);
    import iwl_pkg::*;

    logic signed [DATA_W-1:0] low_mem  [MAX_PAIRS];
    logic signed [DATA_W-1:0] high_mem [MAX_PAIRS];
    logic signed [DATA_W-1:0] even_mem [MAX_PAIRS];

    logic [1:0]               kind_reg;
    logic                     edge_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic signed [DATA_W-1:0] scale_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] rd_low_reg, rd_high_reg, rd_even_reg;
    logic signed [DATA_W-1:0] odd_hold_reg;
    logic signed [DATA_W-1:0] out_sample_reg;
    logic                     out_last_reg, out_error_reg;

    logic                     first_pair, has_room;
    logic signed [DATA_W-1:0] eff_scale;
    logic signed [2*DATA_W-1:0] prod;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [ACC_W-1:0]  tap_data, term;
    logic signed [ACC_W-1:0]  l_ext, h_ext, lift_even, lift_odd;
    logic signed [ACC_W-1:0]  even_full, odd_full;

    // Pair load: scale from the first pair of a row, drop pairs past the store.
    always_comb
    begin
        first_pair = (count_reg == '0) && !ovf_reg;
        eff_scale  = first_pair ? scale : scale_reg;
        prod       = high_sample * eff_scale;
        has_room   = count_reg < CNT_W'(MAX_PAIRS);
        count_next = has_room ? count_reg + CNT_W'(1) : count_reg;
        ovf_next   = ovf_reg | !has_room;
    end

    assign status.count   = count_reg;
    assign status.kind    = kind_reg;
    assign status.row_err = ovf_next || ((kind_reg == WK_DD137) && (count_next < CNT_W'(2)));

    // Read address: neighbor tap with edge handling, or the current index.
    assign rd_addr = cmd.rd_base ? cmd.idx
                   : pick(cmd.idx, tap_offset(kind_reg, cmd.odd, cmd.tap), count_reg, edge_reg);

    // Weighted tap term.
    always_comb
    begin
        tap_data = cmd.odd ? ACC_W'(rd_even_reg) : ACC_W'(rd_high_reg);
        unique case (tap_coef(kind_reg, cmd.odd, cmd.tap))
            COEF_P1: term = tap_data;
            COEF_M1: term = -tap_data;
            COEF_P9: term = (tap_data <<< 3) + tap_data;
            COEF_M9: term = -((tap_data <<< 3) + tap_data);
            default: term = tap_data;
        endcase
    end

    // Lifting results from the base read and the accumulated taps.
    always_comb
    begin
        l_ext = ACC_W'(rd_low_reg);
        h_ext = ACC_W'(rd_high_reg);
        lift_even = (acc_reg + ACC_W'(2)) >>> 2;
        lift_odd  = (acc_reg + ACC_W'(1)) >>> 1;
        if (kind_reg == WK_DD137) begin
            lift_even = (acc_reg + ACC_W'(16)) >>> 5;
            lift_odd  = -((acc_reg + ACC_W'(8)) >>> 4);
        end
        if (kind_reg == WK_CDF53 || kind_reg == WK_DD137) begin
            even_full = l_ext - lift_even;
            odd_full  = h_ext + lift_odd;
        end else begin
            even_full = l_ext - h_ext;
            odd_full  = l_ext + h_ext;
        end
    end

    // Stores: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room) begin
            low_mem[count_reg[ADDR_W-1:0]]  <= low_sample;
            high_mem[count_reg[ADDR_W-1:0]] <= prod[DATA_W-1:0];
        end
        if (cmd.even_we)
            even_mem[cmd.idx] <= even_full[DATA_W-1:0];
        if (cmd.rd_tap || cmd.rd_base) begin
            rd_low_reg  <= low_mem[rd_addr];
            rd_high_reg <= high_mem[rd_addr];
            rd_even_reg <= even_mem[rd_addr];
        end
    end

    // Configuration and row bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg  <= WK_CDF53;
            edge_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            scale_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_WAVELET: kind_reg <= cfg_data[1:0];
                    REG_EDGE:    edge_reg <= cfg_data[0];
                    default:     kind_reg <= kind_reg;
                endcase
            end
            if (cmd.cnt_clr) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.load) begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
                if (first_pair)
                    scale_reg <= scale;
            end
        end
    end

    // Accumulator and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_en)
            acc_reg <= acc_reg + term;
        if (cmd.out_err) begin
            out_sample_reg <= '0;
            out_last_reg   <= 1'b1;
            out_error_reg  <= 1'b1;
        end else if (cmd.out_even) begin
            out_sample_reg <= rd_even_reg;
            out_last_reg   <= 1'b0;
            out_error_reg  <= 1'b0;
            odd_hold_reg   <= odd_full[DATA_W-1:0];
        end else if (cmd.out_odd) begin
            out_sample_reg <= odd_hold_reg;
            out_last_reg   <= cmd.last_idx;
            out_error_reg  <= 1'b0;
        end
    end

    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;
    assign out_error  = out_error_reg;

endmodule

// ----- rtl/iwl_controller.sv -----
// Controller: sequences pair loading, tap reads for even then odd samples, output and the error item.
// Depends on iwl_pkg; commands iwl_datapath.
`timescale 1ns / 1ps

module iwl_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pair_valid,
    input  logic                pair_last,
    output logic                pair_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  iwl_pkg::dp_status_t status,
    output iwl_pkg::ctrl_cmd_t  cmd
);
    import iwl_pkg::*;

    typedef enum logic [8:0] {
        ST_LOAD     = 9'b000000001,
        ST_TAP_RD   = 9'b000000010,
        ST_TAP_ACC  = 9'b000000100,
        ST_BASE_RD  = 9'b000001000,
        ST_BASE_USE = 9'b000010000,
        ST_EMIT_E   = 9'b000100000,
        ST_EMIT_O   = 9'b001000000,
        ST_ERR      = 9'b010000000,
        ST_SPARE    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic              odd_reg, odd_next;
    logic [2:0]        ntaps;
    logic              last_idx;
    state_t            sample_start;

    assign ntaps        = tap_count(status.kind);
    assign last_idx     = {1'b0, idx_reg} == status.count - CNT_W'(1);
    assign sample_start = (ntaps != 3'd0) ? ST_TAP_RD : ST_BASE_RD;
    assign pair_ready   = (state_reg == ST_LOAD);
    assign out_valid    = (state_reg == ST_EMIT_E) || (state_reg == ST_EMIT_O)
                       || (state_reg == ST_ERR);

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        tap_next     = tap_reg;
        odd_next     = odd_reg;
        cmd          = '0;
        cmd.idx      = idx_reg;
        cmd.tap      = tap_reg;
        cmd.odd      = odd_reg;
        cmd.last_idx = last_idx;
        unique case (state_reg)
            ST_LOAD: begin
                if (pair_valid) begin
                    cmd.load = 1'b1;
                    if (pair_last) begin
                        if (status.row_err) begin
                            cmd.out_err = 1'b1;
                            state_next  = ST_ERR;
                        end else begin
                            cmd.acc_clr = 1'b1;
                            idx_next    = '0;
                            tap_next    = '0;
                            odd_next    = 1'b0;
                            state_next  = sample_start;
                        end
                    end
                end
            end
            ST_TAP_RD: begin
                cmd.rd_tap = 1'b1;
                state_next = ST_TAP_ACC;
            end
            ST_TAP_ACC: begin
                cmd.acc_en = 1'b1;
                if ({1'b0, tap_reg} == ntaps - 3'd1) begin
                    tap_next   = '0;
                    state_next = ST_BASE_RD;
                end else begin
                    tap_next   = tap_reg + TAP_W'(1);
                    state_next = ST_TAP_RD;
                end
            end
            ST_BASE_RD: begin
                cmd.rd_base = 1'b1;
                state_next  = ST_BASE_USE;
            end
            ST_BASE_USE: begin
                cmd.acc_clr = 1'b1;
                if (!odd_reg) begin
                    cmd.even_we = 1'b1;
                    if (last_idx) begin
                        odd_next = 1'b1;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                    state_next = sample_start;
                end else begin
                    cmd.out_even = 1'b1;
                    state_next   = ST_EMIT_E;
                end
            end
            ST_EMIT_E: begin
                if (out_ready) begin
                    cmd.out_odd = 1'b1;
                    state_next  = ST_EMIT_O;
                end
            end
            ST_EMIT_O: begin
                if (out_ready) begin
                    if (last_idx) begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = sample_start;
                    end
                end
            end
            ST_ERR: begin
                if (out_ready) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
            tap_reg   <= '0;
            odd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            tap_reg   <= tap_next;
            odd_reg   <= odd_next;
        end
    end

endmodule

// ----- rtl/inverse_wavelet_lifting_1d.sv -----
// Inverse 1D lifting wavelet transform, top level.
// Depends on iwl_pkg, iwl_pair_if, iwl_sample_if, iwl_controller, iwl_datapath.
`timescale 1ns / 1ps

// A row of up to 32 lowpass/highpass pairs is loaded at one pair per cycle; the pair
// marked last starts reconstruction and the block then takes no input until the row's
// 2N samples (even, odd, ...) have all been taken, or the single error item of an
// overflowed row or one-pair 13/7 row. Each sample's lifting term is accumulated one
// tap at a time through the registered read port of the coefficient stores; with T
// taps (0 Haar, 2 for 5/3, 4 for 13/7) each sample reads and adds its taps, then reads
// its base entry. The even pass fills the even store, the odd pass emits each even and
// odd sample in turn. Configuration writes act on the row in progress too.
module inverse_wavelet_lifting_1d (
    input  logic                           clk,
    input  logic                           rst_n,
    iwl_pair_if.sink                       pairs,
    iwl_sample_if.source                   samples,
    input  logic                           cfg_we,
    input  logic [iwl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iwl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import iwl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer.
    iwl_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pairs.valid),
        .pair_last  (pairs.last_pair),
        .pair_ready (pairs.ready),
        .out_valid  (samples.valid),
        .out_ready  (samples.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Stores and arithmetic.
    iwl_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .low_sample  (pairs.low_sample),
        .high_sample (pairs.high_sample),
        .scale       (pairs.scale),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .out_sample  (samples.sample),
        .out_last    (samples.last_sample),
        .out_error   (samples.error)
    );

endmodule

// ----- rtl/iwl_checker.sv -----
// Port-level checks of the inverse lifting block, bound to its top level.
// Depends on inverse_wavelet_lifting_1d_defines.svh.
`timescale 1ns / 1ps
`include "inverse_wavelet_lifting_1d_defines.svh"

module iwl_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_error
);
    // An error item always closes its row.
    `IWL_ASSERT_SAME(a_err_last, clk, rst_n, out_valid && out_error, out_last)
    // Input is held off while a row is being emitted.
    `IWL_ASSERT_SAME(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // After the final item of a row the block returns to loading.
    `IWL_ASSERT_NEXT(a_row_done, clk, rst_n, out_valid && out_ready && out_last, !out_valid)
    // A pair that does not end its row causes no output.
    `IWL_ASSERT_NEXT(a_mid_row, clk, rst_n, in_valid && in_ready && !in_last, !out_valid)
endmodule

bind inverse_wavelet_lifting_1d iwl_checker u_iwl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .in_last   (pairs.last_pair),
    .out_valid (samples.valid),
    .out_ready (samples.ready),
    .out_last  (samples.last_sample),
    .out_error (samples.error)
);

// ----- verif/inverse_wavelet_lifting_1d_tb.sv -----
// Self-checking testbench for the inverse 1D lifting wavelet block.
// Depends on iwl_pkg, iwl_pair_if, iwl_sample_if and inverse_wavelet_lifting_1d.
`timescale 1ns / 1ps

module inverse_wavelet_lifting_1d_tb;
    import iwl_pkg::*;

    localparam int IDLE_LIMIT  = 6000;
    localparam int SETTLE_CYCS = 16;
    localparam int ITEM_TARGET = 370;

    typedef struct {
        logic signed [DATA_W-1:0] sample;
        logic                     last_sample;
        logic                     error;
    } sample_exp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    iwl_pair_if   pair_ch();
    iwl_sample_if sample_ch();

    inverse_wavelet_lifting_1d DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pairs     (pair_ch),
        .samples   (sample_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow state of the block.
    logic signed [DATA_W-1:0] low_row [MAX_PAIRS];
    logic signed [DATA_W-1:0] high_row [MAX_PAIRS];
    logic signed [DATA_W-1:0] even_row [MAX_PAIRS];
    int                       row_pairs = 0;
    logic signed [DATA_W-1:0] row_scale = '0;
    logic                     row_overflow = 1'b0;
    logic [1:0]               kind_sh = WK_CDF53;
    logic                     replicate_sh = 1'b0;

    sample_exp_t expected_samples[$];
    int          mismatches = 0;
    int          pairs_sent = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          cyc = 0;
    int          idle_cycles = 0;

    function automatic logic signed [DATA_W-1:0] wrap16(input int v);
        return v[DATA_W-1:0];
    endfunction

    // Edge handling on a shadow index.
    function automatic int edge_idx(input int j, input int n);
        if (replicate_sh)
            return (j < 0) ? 0 : ((j >= n) ? n - 1 : j);
        return (j + 4 * n) % n;
    endfunction

    function automatic int hv(input int j, input int n);
        return int'(high_row[edge_idx(j, n)]);
    endfunction

    function automatic int ev(input int j, input int n);
        return int'(even_row[edge_idx(j, n)]);
    endfunction

    task automatic push_sample(input int s, input logic lst, input logic err);
        sample_exp_t e;
        e.sample = wrap16(s);
        e.last_sample = lst;
        e.error = err;
        expected_samples.push_back(e);
    endtask

    // Shadow load of each taken pair; reconstruction of the row once its last pair is taken.
    task automatic predict_pair(input logic signed [15:0] lo, input logic signed [15:0] hi,
                                input logic signed [15:0] sc, input logic lst);
        int n;
        int t;
        int o;
        if (row_pairs == 0 && !row_overflow)
            row_scale = sc;
        if (row_pairs < MAX_PAIRS) begin
            low_row[row_pairs] = lo;
            high_row[row_pairs] = wrap16(int'(hi) * int'(row_scale));
            row_pairs++;
        end else begin
            row_overflow = 1'b1;
        end
        if (!lst)
            return;
        n = row_pairs;
        row_pairs = 0;
        if (row_overflow || (kind_sh == WK_DD137 && n < 2)) begin
            row_overflow = 1'b0;
            push_sample(0, 1'b1, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            if (kind_sh == WK_CDF53)
                t = (hv(i, n) + hv(i - 1, n) + 2) >>> 2;
            else if (kind_sh == WK_DD137)
                t = (-hv(i + 1, n) - hv(i - 2, n) + 9 * (hv(i, n) + hv(i - 1, n)) + 16) >>> 5;
            else
                t = hv(i, n);
            even_row[i] = wrap16(int'(low_row[i]) - t);
        end
        for (int i = 0; i < n; i++) begin
            if (kind_sh == WK_CDF53)
                o = hv(i, n) + ((ev(i + 1, n) + ev(i, n) + 1) >>> 1);
            else if (kind_sh == WK_DD137)
                o = hv(i, n) - ((ev(i + 2, n) + ev(i - 1, n)
                                 - 9 * (ev(i + 1, n) + ev(i, n)) + 8) >>> 4);
            else
                o = int'(low_row[i]) + hv(i, n);
            push_sample(even_row[i], 1'b0, 1'b0);
            push_sample(o, i == n - 1, 1'b0);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sends one pair, idling in bursts with random gaps.
    task automatic send_pair(input logic signed [15:0] lo, input logic signed [15:0] hi,
                             input logic signed [15:0] sc, input logic lst);
        if (burst_left == 0) begin
            pair_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
        pair_ch.valid = 1'b1;
        pair_ch.low_sample = lo;
        pair_ch.high_sample = hi;
        pair_ch.scale = sc;
        pair_ch.last_pair = lst;
        do @(posedge clk); while (!pair_ch.ready);
        predict_pair(lo, hi, sc, lst);
        burst_left--;
        pairs_sent++;
        @(negedge clk);
        pair_ch.valid = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_value(input bit wide);
        if (wide)
            return 16'($urandom);
        return 16'($urandom_range(0, 400)) - 16'sd200;
    endfunction

    task automatic send_row(input int n, input bit wide);
        logic signed [15:0] sc;
        sc = wide ? 16'($urandom) : 16'($urandom_range(0, 6)) - 16'sd3;
        for (int i = 0; i < n; i++)
            send_pair(rand_value(wide), rand_value(wide), (i == 0) ? sc : rand_value(1),
                      i == n - 1);
    endtask

    // Waits for every expected item, then lets the block settle.
    task automatic drain;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        if (idx == REG_WAVELET)
            kind_sh = val;
        else
            replicate_sh = val[0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_mode(input logic [1:0] kind, input logic rep);
        drain();
        write_reg(REG_WAVELET, kind);
        write_reg(REG_EDGE, {1'b0, rep});
    endtask

    // Directed rows: extremes, each wavelet, edge modes and the one-pair 13/7 error.
    task automatic test_directed;
        send_pair(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 16'sh0001, 1'b1);
        send_pair(16'sh1234, 16'sh0042, 16'sh0003, 1'b1);
        set_mode(WK_HAAR, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh8000, 16'sh0000, 1'b0);
        send_pair(16'sh0000, 16'shffff, 16'sh0005, 1'b1);
        set_mode(WK_DD137, 1'b0);
        send_pair(16'sh0100, 16'sh0010, 16'sh0002, 1'b1);
        send_row(3, 1'b1);
        set_mode(WK_DD137, 1'b1);
        send_row(2, 1'b0);
        send_row(2, 1'b1);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
        set_mode(WK_CDF53, 1'b1);
        send_row(1, 1'b1);
        send_row(3, 1'b0);
        set_mode(2'd3, 1'b0);
        send_row(2, 1'b1);
    endtask

    // The sender holds off until every expected item has come.
    task automatic test_pause;
        set_mode(WK_CDF53, 1'b0);
        send_row(4, 1'b1);
        drain();
        send_row(5, 1'b0);
    endtask

    // Random rows over every setting, mostly short, some full or overflowing.
    task automatic test_random;
        int n;
        while (pairs_sent < ITEM_TARGET) begin
            set_mode(2'($urandom_range(0, 3)), 1'($urandom));
            stall_mode = $urandom_range(0, 2);
            repeat ($urandom_range(2, 5)) begin
                case ($urandom_range(0, 15))
                    0:       n = 32;
                    1:       n = $urandom_range(33, 35);
                    2, 3:    n = $urandom_range(9, 31);
                    default: n = $urandom_range(1, 8);
                endcase
                send_row(n, $urandom_range(0, 2) == 0);
            end
        end
    endtask

    // Result side stalls on its own pattern.
    always @(negedge clk) begin
        cyc <= cyc + 1;
        case (stall_mode)
            0:       sample_ch.ready <= 1'b1;
            1:       sample_ch.ready <= ($urandom_range(0, 3) != 0);
            default: sample_ch.ready <= ((cyc % 5) < 2);
        endcase
    end

    // Compare each taken item with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && sample_ch.valid && sample_ch.ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected item", sample_ch.sample, 0);
            end else begin
                sample_exp_t e;
                e = expected_samples.pop_front();
                if (sample_ch.sample !== e.sample)
                    report_mismatch("sample", sample_ch.sample, e.sample);
                if (sample_ch.last_sample !== e.last_sample)
                    report_mismatch("last_sample", sample_ch.last_sample, e.last_sample);
                if (sample_ch.error !== e.error)
                    report_mismatch("error", sample_ch.error, e.error);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk) begin
        if ((pair_ch.valid && pair_ch.ready) || (sample_ch.valid && sample_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("inverse_wavelet_lifting_1d_tb: errors");
            $finish;
        end
    end

    initial begin
        pair_ch.valid = 1'b0;
        pair_ch.low_sample = '0;
        pair_ch.high_sample = '0;
        pair_ch.scale = '0;
        pair_ch.last_pair = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_pause();
        test_random();
        drain();
        if (mismatches == 0)
            $display("inverse_wavelet_lifting_1d_tb: clean");
        else
            $display("inverse_wavelet_lifting_1d_tb: errors");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/iwl_pkg.sv
rtl/iwl_pair_if.sv
rtl/iwl_sample_if.sv
rtl/iwl_datapath.sv
rtl/iwl_controller.sv
rtl/inverse_wavelet_lifting_1d.sv
rtl/iwl_checker.sv
verif/inverse_wavelet_lifting_1d_tb.sv
